@@ rtl/core/tkm_pkg.sv @@
// ----------------------------------------------------------------------------
// tkm_pkg
// Shared types and codes for the timestamp k-way stream merger.
// ----------------------------------------------------------------------------
`default_nettype none

package tkm_pkg;

  // Head key: seconds above a full 20-bit microseconds field
  localparam int SecW = 32;
  localparam int MicW = 20;
  localparam int KeyW = SecW + MicW;

  typedef enum logic [1:0] {
    CMD_OFFER = 2'd0,
    CMD_END   = 2'd1,
    CMD_ERROR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PS_AWAIT = 2'd0,
    PS_HEAD  = 2'd1,
    PS_END   = 2'd2,
    PS_FAIL  = 2'd3
  } port_state_e;

  typedef enum logic [1:0] {
    RES_SELECT = 2'd0,
    RES_END    = 2'd1,
    RES_ERROR  = 2'd2
  } res_status_e;

  typedef enum logic {
    CFG_MERGE_MODE   = 1'b0,
    CFG_ACTIVE_PORTS = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic any_await;
    logic found_head;
    logic any_live;
  } scan_res_t;

endpackage

`default_nettype wire

@@ rtl/core/tkm_head_mem.sv @@
// ----------------------------------------------------------------------------
// tkm_head_mem
// Head timestamp store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tkm_head_mem
  import tkm_pkg::*;
#(
  parameter int NUM_PORTS = 8,
  parameter int IdxW      = 3
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [KeyW-1:0] wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output logic      [KeyW-1:0] rdata_o
);

  logic [KeyW-1:0] mem_q [NUM_PORTS];
  logic [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/tkm_scan_unit.sv @@
// ----------------------------------------------------------------------------
// tkm_scan_unit
// Shared compare unit: folds one port per step into the running scan result.
// ----------------------------------------------------------------------------
`default_nettype none

module tkm_scan_unit
  import tkm_pkg::*;
#(
  parameter int IdxW = 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire scan_ctl_t       ctl_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire port_state_e     st_i,
  input  wire logic [KeyW-1:0] key_i,
  output scan_res_t            res_o,
  output logic      [IdxW-1:0] best_idx_o,
  output logic      [IdxW-1:0] first_idx_o
);

  scan_res_t       res_q, res_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [IdxW-1:0] first_q, first_d;
  logic [KeyW-1:0] best_key_q, best_key_d;
  logic            take_head;
  logic            live;

  // <= so that on equal keys the later (higher) port wins
  assign take_head = (st_i == PS_HEAD) && (!res_q.found_head || (key_i <= best_key_q));
  assign live      = (st_i != PS_END) && (st_i != PS_FAIL);

  always_comb begin
    res_d      = res_q;
    best_d     = best_q;
    first_d    = first_q;
    best_key_d = best_key_q;
    if (ctl_i.clear) begin
      res_d = '0;
    end else if (ctl_i.step) begin
      if (st_i == PS_AWAIT) begin
        res_d.any_await = 1'b1;
      end
      if (take_head) begin
        res_d.found_head = 1'b1;
        best_d           = idx_i;
        best_key_d       = key_i;
      end
      if (live && !res_q.any_live) begin
        res_d.any_live = 1'b1;
        first_d        = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    first_q    <= first_d;
    best_key_q <= best_key_d;
  end

  assign res_o       = res_q;
  assign best_idx_o  = best_q;
  assign first_idx_o = first_q;

endmodule

`default_nettype wire

@@ rtl/core/timestamp_kway_stream_merger.sv @@
// ----------------------------------------------------------------------------
// timestamp_kway_stream_merger
// Merges per-port packet head events into one selection stream, either by
// earliest head timestamp or by appending ports in index order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o | command, source_port, ts_*
//  out     | output    | out_valid_o/out_stall_i | status, selected_port
//  cfg     | input     | cfg_we_i             | cfg_index_i, cfg_data_i
//
//  - An error event is accepted and then goes straight to the result load.
//  - Head and end events pass through one accept state, N scan steps
//    through the shared compare unit (one port per cycle, set by the single
//    head memory read port), a drain step for the registered read, a decide
//    step and, when they give a result, a load; N is the clamped active
//    port count.
//  - Ignored events (command 3, inactive port) are accepted without leaving idle.
//  - in_stall_o is high while a transaction is in work; the output register
//    holds a finished result while the next transaction is taken, and a new
//    result waits in the load cycle while that register is still stalled.
//  - Reset puts every port in awaiting state; head memory needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_kway_stream_merger
  import tkm_pkg::*;
#(
  parameter int NUM_PORTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  // event input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [2:0]  source_port_i,
  input  wire logic [31:0] ts_seconds_i,
  input  wire logic [19:0] ts_micros_i,
  // selection output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [2:0]       selected_port_o
);

  localparam int IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CntW = $clog2(NUM_PORTS + 1);

  // --- configuration registers ---
  logic       merge_mode_q;
  logic [3:0] active_ports_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_mode_q   <= 1'b0;
      active_ports_q <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MERGE_MODE:   merge_mode_q   <= cfg_data_i[0];
        CFG_ACTIVE_PORTS: active_ports_q <= cfg_data_i;
        default:          merge_mode_q   <= merge_mode_q;
      endcase
    end
  end

  // Clamp the active count to 1..NUM_PORTS
  logic [CntW-1:0] port_cnt;
  logic [IdxW-1:0] last_idx;

  always_comb begin
    if (active_ports_q == 4'd0) begin
      port_cnt = CntW'(1);
    end else if (int'(active_ports_q) > NUM_PORTS) begin
      port_cnt = CntW'(NUM_PORTS);
    end else begin
      port_cnt = CntW'(active_ports_q);
    end
  end

  assign last_idx = IdxW'(port_cnt - CntW'(1));

  // --- per-port status, cleared to awaiting by reset ---
  port_state_e     port_status_q [NUM_PORTS];
  logic            st_we;
  logic [IdxW-1:0] st_waddr;
  port_state_e     st_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_status_q[i] <= PS_AWAIT;
      end
    end else if (st_we) begin
      port_status_q[st_waddr] <= st_wdata;
    end
  end

  // --- latched transaction ---
  cmd_e            cmd_q;
  logic [2:0]      port_q;
  logic [KeyW-1:0] item_key_q;

  // --- sequencer and scan index ---
  seq_state_e      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;
  logic            port_ok;
  cmd_e            in_cmd;

  assign in_cmd  = cmd_e'(command_i);
  assign port_ok = int'(source_port_i) < int'(port_cnt);
  assign accept  = in_valid_i && !in_stall_o;

  // Scan stage: effective status of the port under the index, with this
  // transaction's own update folded in when the index reaches its port.
  port_state_e cur_st, eff_st;
  logic        hit, take_item;

  assign cur_st = port_status_q[idx_q];
  assign hit    = (idx_q == IdxW'(port_q));

  always_comb begin
    eff_st    = cur_st;
    take_item = 1'b0;
    if (hit && (cmd_q == CMD_OFFER) && !merge_mode_q && (cur_st == PS_AWAIT)) begin
      eff_st    = PS_HEAD;
      take_item = 1'b1;
    end else if (hit && (cmd_q == CMD_END) && (cur_st != PS_FAIL)) begin
      eff_st = PS_END;
    end
  end

  // Compare stage, registered after the scan stage: aligned with the head memory read
  logic            p_valid_q;
  logic [IdxW-1:0] p_idx_q;
  port_state_e     p_st_q;
  logic            p_take_q;
  logic [KeyW-1:0] mem_key;
  logic [KeyW-1:0] cmp_key;

  assign cmp_key = p_take_q ? item_key_q : mem_key;

  tkm_head_mem #(
    .NUM_PORTS (NUM_PORTS),
    .IdxW      (IdxW)
  ) u_head_mem (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_SCAN) && take_item),
    .waddr_i (idx_q),
    .wdata_i (item_key_q),
    .raddr_i (idx_q),
    .rdata_o (mem_key)
  );

  scan_ctl_t       scan_ctl;
  scan_res_t       scan_res;
  logic [IdxW-1:0] best_idx;
  logic [IdxW-1:0] first_idx;

  assign scan_ctl.clear = accept;
  assign scan_ctl.step  = p_valid_q;

  tkm_scan_unit #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .idx_i       (p_idx_q),
    .st_i        (p_st_q),
    .key_i       (cmp_key),
    .res_o       (scan_res),
    .best_idx_o  (best_idx),
    .first_idx_o (first_idx)
  );

  // --- pending result and output register ---
  res_status_e res_status_q, res_status_d;
  logic [2:0]  res_port_q, res_port_d;
  logic        out_valid_q;
  res_status_e out_status_q;
  logic [2:0]  out_port_q;
  logic        out_load;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    st_we        = 1'b0;
    st_waddr     = idx_q;
    st_wdata     = eff_st;
    res_status_d = res_status_q;
    res_port_d   = res_port_q;
    out_load     = 1'b0;
    in_stall_o   = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept && port_ok && (in_cmd != CMD_NONE)) begin
          if (in_cmd == CMD_ERROR) begin
            st_we        = 1'b1;
            st_waddr     = IdxW'(source_port_i);
            st_wdata     = PS_FAIL;
            res_status_d = RES_ERROR;
            res_port_d   = source_port_i;
            state_d      = ST_EMIT;
          end else begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        st_we = (eff_st != cur_st);
        if (idx_q == last_idx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        if (!merge_mode_q) begin
          if (!scan_res.any_await) begin
            state_d = ST_EMIT;
            if (scan_res.found_head) begin
              st_we        = 1'b1;
              st_waddr     = best_idx;
              st_wdata     = PS_AWAIT;
              res_status_d = RES_SELECT;
              res_port_d   = 3'(best_idx);
            end else begin
              res_status_d = RES_END;
              res_port_d   = 3'd0;
            end
          end
        end else if (cmd_q == CMD_OFFER) begin
          // append: forward only from the lowest live port
          if (scan_res.any_live && (first_idx == IdxW'(port_q))) begin
            st_we        = 1'b1;
            st_waddr     = first_idx;
            st_wdata     = PS_AWAIT;
            res_status_d = RES_SELECT;
            res_port_d   = port_q;
            state_d      = ST_EMIT;
          end
        end else if (!scan_res.any_live) begin
          res_status_d = RES_END;
          res_port_d   = 3'd0;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      p_valid_q <= (state_q == ST_SCAN);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_cmd;
      port_q     <= source_port_i;
      item_key_q <= {ts_seconds_i, ts_micros_i};
    end
    p_idx_q      <= idx_q;
    p_st_q       <= eff_st;
    p_take_q     <= take_item;
    res_status_q <= res_status_d;
    res_port_q   <= res_port_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_port_q   <= res_port_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign selected_port_o = out_port_q;

`ifndef SYNTH
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("output valid rose outside result load");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (int'(idx_q) < int'(port_cnt)))
    else $error("scan index beyond active ports");

  a_decide_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> $past(state_q) == ST_DRAIN)
    else $error("decide without drained compare stage");

  a_best_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DECIDE) && !merge_mode_q && scan_res.found_head)
      |-> (port_status_q[best_idx] == PS_HEAD))
    else $error("selected port holds no head");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamp k-way stream merger. Port events go
// in through the valid/stall channel, and a cycle-free model in the
// port_merge_model class predicts each selection, end or error report. Every
// accepted result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

import tkm_pkg::*;

typedef struct packed {
  res_status_e status;
  logic [2:0]  port;
} selection_t;

// Mirror of the per-port state plus the queue of predicted reports
class port_merge_model;
  logic        mode;
  logic [3:0]  port_cfg;
  port_state_e state_q [8];
  logic [31:0] head_sec [8];
  logic [19:0] head_mic [8];
  selection_t  pending_selections [$];
  int unsigned errors;

  function new();
    mode     = 1'b0;
    port_cfg = 4'd2;
    foreach (state_q[i]) state_q[i] = PS_AWAIT;
    errors   = 0;
  endfunction

  function void write_reg(cfg_index_e idx, logic [3:0] val);
    if (idx == CFG_MERGE_MODE) mode = val[0];
    else port_cfg = val;
  endfunction

  // 0 acts as 1, anything above the port count is clamped
  function int port_count();
    int n;
    n = int'(port_cfg);
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    return n;
  endfunction

  function int pending();
    return pending_selections.size();
  endfunction

  function void queue_result(res_status_e st, int prt);
    selection_t r;
    r.status = st;
    r.port   = prt[2:0];
    pending_selections.push_back(r);
  endfunction

  // lowest active port still able to deliver, or the port count if none
  function int first_live();
    int n;
    n = port_count();
    for (int i = 0; i < n; i++)
      if (state_q[i] != PS_END && state_q[i] != PS_FAIL) return i;
    return n;
  endfunction

  function int live_total();
    int cnt;
    cnt = 0;
    foreach (state_q[i]) if (state_q[i] != PS_END && state_q[i] != PS_FAIL) cnt++;
    return cnt;
  endfunction

  function int random_awaiting();
    int cand [$];
    int n;
    n = port_count();
    for (int i = 0; i < n; i++) if (state_q[i] == PS_AWAIT) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  // Earliest head wins; <= lets a tie go to the higher port
  function void pick_earliest_head();
    int          n;
    bit          found;
    int          best;
    logic [51:0] best_key;
    logic [51:0] key;
    n        = port_count();
    found    = 1'b0;
    best     = 0;
    best_key = '0;
    for (int i = 0; i < n; i++) if (state_q[i] == PS_AWAIT) return;
    for (int i = 0; i < n; i++) begin
      if (state_q[i] == PS_HEAD) begin
        key = {head_sec[i], head_mic[i]};
        if (!found || key <= best_key) begin
          found    = 1'b1;
          best     = i;
          best_key = key;
        end
      end
    end
    if (!found) begin
      queue_result(RES_END, 0);
    end else begin
      state_q[best] = PS_AWAIT;
      queue_result(RES_SELECT, best);
    end
  endfunction

  function void note_event(cmd_e c, logic [2:0] prt, logic [31:0] s, logic [19:0] m);
    int n;
    n = port_count();
    if (c == CMD_NONE || int'(prt) >= n) return;
    if (c == CMD_ERROR) begin
      state_q[prt] = PS_FAIL;
      queue_result(RES_ERROR, int'(prt));
      return;
    end
    if (mode == 1'b0) begin
      if (c == CMD_OFFER) begin
        if (state_q[prt] == PS_AWAIT) begin
          head_sec[prt] = s;
          head_mic[prt] = m;
          state_q[prt]  = PS_HEAD;
        end
      end else if (state_q[prt] != PS_FAIL) begin
        state_q[prt] = PS_END;
      end
      pick_earliest_head();
      return;
    end
    if (c == CMD_OFFER) begin
      if (first_live() == int'(prt)) begin
        state_q[prt] = PS_AWAIT;
        queue_result(RES_SELECT, int'(prt));
      end
    end else begin
      if (state_q[prt] != PS_FAIL) state_q[prt] = PS_END;
      if (first_live() == n) queue_result(RES_END, 0);
    end
  endfunction

  function void check_selection(logic [1:0] st, logic [2:0] prt);
    selection_t want;
    if (pending_selections.size() == 0) begin
      $display("%0t: unexpected result, status %0d port %0d", $time, st, prt);
      errors++;
      return;
    end
    want = pending_selections.pop_front();
    if (st !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      errors++;
    end
    if (prt !== want.port) begin
      $display("%0t: selected_port expected %0d actual %0d", $time, want.port, prt);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int RandomItems = 1900;
  localparam int CfgSettle   = 20;   // outlasts a head/end event at 8 ports

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  cfg_index_e  cfg_index   = CFG_MERGE_MODE;
  logic [3:0]  cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic [1:0]  command     = '0;
  logic [2:0]  source_port = '0;
  logic [31:0] ts_seconds  = '0;
  logic [19:0] ts_micros   = '0;
  logic        out_stall   = 1'b0;
  logic        calm        = 1'b0;   // stretch with no idling on either side
  int unsigned hold_left   = 0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [2:0]  selected_port_o;

  port_merge_model model;

  timestamp_kway_stream_merger #(
    .NUM_PORTS (8)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .command_i       (command),
    .source_port_i   (source_port),
    .ts_seconds_i    (ts_seconds),
    .ts_micros_i     (ts_micros),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_o        (status_o),
    .selected_port_o (selected_port_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor: sample both handshakes on the pre-edge values. A result can
  // never come out in the cycle its event goes in, so the order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o)
        model.note_event(cmd_e'(command), source_port, ts_seconds, ts_micros);
      if (out_valid_o && !out_stall)
        model.check_selection(status_o, selected_port_o);
    end
  end

  // Receiver back-pressure: short random bursts, ~30% of cycles
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(99) < 15) begin
      hold_left <= $urandom_range(3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One event transaction. Returns at the edge that accepted it, with valid
  // still high: the caller either drives the next event or drops valid in
  // that same step.
  task automatic put_event(input cmd_e c, input logic [2:0] prt,
                           input logic [31:0] s, input logic [19:0] m);
    int gap;
    if (!calm && $urandom_range(99) < 30) begin
      // long gaps land on every phase of a head/end event's scan
      gap = ($urandom_range(2) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= c;
    source_port <= prt;
    ts_seconds  <= s;
    ts_micros   <= m;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
  endtask

  // Register write only with nothing in flight. Events that give no result
  // may still be scanning, hence the settle time.
  task automatic write_cfg(input cfg_index_e idx, input logic [3:0] val);
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (CfgSettle) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.write_reg(idx, val);
  endtask

  // Mostly well-formed traffic: offers to ports that are waiting (timestamp
  // mode) or to the port being appended, plus a trickle of noise and kills.
  task automatic random_event(output bit counted);
    int          r;
    int          p;
    cmd_e        c;
    logic [2:0]  prt;
    logic [31:0] s;
    logic [19:0] m;
    r = $urandom_range(999);
    s = $urandom;
    m = 20'($urandom);
    case ($urandom_range(3))
      0: begin                    // tight range: lots of ties
        s = $urandom_range(3);
        m = 20'($urandom_range(3));
      end
      1: s = $urandom_range(40);
      2: ;
      default: begin              // corners
        s = $urandom_range(1) ? '1 : '0;
        m = $urandom_range(1) ? '1 : '0;
      end
    endcase
    prt = 3'($urandom_range(7));
    if (r < 30) begin
      c = CMD_NONE;
    end else if (r < 34 && model.live_total() > 2) begin
      // ports never come back, so keep at least two alive
      c = $urandom_range(1) ? CMD_END : CMD_ERROR;
    end else begin
      c = CMD_OFFER;
      p = (model.mode == 1'b0) ? model.random_awaiting() : model.first_live();
      if (p >= 0 && p < model.port_count() && $urandom_range(99) < 80) prt = p[2:0];
    end
    counted = (c != CMD_NONE) && (int'(prt) < model.port_count());
    put_event(c, prt, s, m);
  endtask

  initial begin
    int done_items;
    int phase;
    int phase_len;
    int k;
    int p;
    bit counted;

    model = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset config, timestamp mode, two ports ----
    put_event(CMD_OFFER, 3'd0, 32'd1, 20'd999999);
    put_event(CMD_OFFER, 3'd1, 32'd1, 20'd999999);      // tie: port 1 wins
    put_event(CMD_OFFER, 3'd0, 32'd0, 20'd0);           // port 0 busy: dropped
    put_event(CMD_OFFER, 3'd1, 32'd0, 20'hFFFFF);       // seconds decide first
    put_event(CMD_OFFER, 3'd1, 32'd1, 20'd1000000);     // micros above 999999
    put_event(CMD_OFFER, 3'd0, 32'hFFFFFFFF, 20'hFFFFF);
    put_event(CMD_NONE, 3'd0, 32'd0, 20'd0);            // unused command
    put_event(CMD_OFFER, 3'd5, 32'd0, 20'd0);           // inactive port
    put_event(CMD_OFFER, 3'd1, 32'hFFFFFFFF, 20'hFFFFF);// tie at the top

    // count above the port range is clamped to 8
    write_cfg(CFG_ACTIVE_PORTS, 4'd15);
    for (k = 1; k < 8; k++) put_event(CMD_OFFER, k[2:0], k, 20'(k * 3));

    // append mode: only the lowest live port passes
    write_cfg(CFG_MERGE_MODE, 4'd1);
    put_event(CMD_OFFER, 3'd0, 32'hA5A5A5A5, 20'h5A5A5);
    put_event(CMD_OFFER, 3'd4, 32'd7, 20'd7);

    // count of zero acts as one
    write_cfg(CFG_ACTIVE_PORTS, 4'd0);
    write_cfg(CFG_MERGE_MODE, 4'd0);
    put_event(CMD_OFFER, 3'd0, 32'h5A5A5A5A, 20'hA5A5A);
    put_event(CMD_OFFER, 3'd3, 32'd0, 20'd0);
    write_cfg(CFG_ACTIVE_PORTS, 4'd1);
    put_event(CMD_OFFER, 3'd0, 32'd0, 20'd0);

    // ---- random phases, each with its own settings ----
    done_items = 0;
    phase      = 0;
    while (done_items < RandomItems) begin
      write_cfg(CFG_MERGE_MODE, 4'((phase == 0) ? 0 : $urandom_range(1)));
      if (phase == 0) write_cfg(CFG_ACTIVE_PORTS, 4'd8);
      else if ($urandom_range(9) == 0) write_cfg(CFG_ACTIVE_PORTS, 4'($urandom_range(15)));
      else write_cfg(CFG_ACTIVE_PORTS, 4'($urandom_range(1, 8)));
      phase_len = $urandom_range(80, 200);
      for (k = 0; k < phase_len && done_items < RandomItems; k++) begin
        calm <= (done_items >= 500 && done_items < 800);
        random_event(counted);
        if (counted) done_items++;
      end
      phase++;
    end
    calm <= 1'b0;

    // ---- wind-down: ends, errors, and reports once every port is done ----
    write_cfg(CFG_MERGE_MODE, 4'd1);
    write_cfg(CFG_ACTIVE_PORTS, 4'd8);
    put_event(CMD_END, 3'd0, 32'd0, 20'd0);
    p = model.first_live();
    put_event(CMD_OFFER, p[2:0], $urandom, 20'($urandom));
    put_event(CMD_ERROR, p[2:0], 32'd0, 20'd0);
    p = model.first_live();
    put_event(CMD_OFFER, p[2:0], $urandom, 20'($urandom));
    put_event(CMD_OFFER, 3'd7, $urandom, 20'($urandom));

    write_cfg(CFG_MERGE_MODE, 4'd0);
    for (k = 0; k < 8; k++) begin
      put_event(CMD_END, k[2:0], 32'd0, 20'd0);
      p = model.random_awaiting();
      if (p >= 0) put_event(CMD_OFFER, p[2:0], $urandom, 20'($urandom));
    end
    put_event(CMD_ERROR, 3'd3, 32'd0, 20'd0);   // error on an ended port
    put_event(CMD_END, 3'd3, 32'd0, 20'd0);     // failed port stays failed
    put_event(CMD_END, 3'd0, 32'd0, 20'd0);     // end reported again
    put_event(CMD_OFFER, 3'd2, $urandom, 20'($urandom));
    write_cfg(CFG_MERGE_MODE, 4'd1);
    put_event(CMD_END, 3'd1, 32'd0, 20'd0);
    put_event(CMD_OFFER, 3'd2, $urandom, 20'($urandom));
    put_event(CMD_ERROR, 3'd4, 32'd0, 20'd0);
    in_valid <= 1'b0;

    // let the monitor note the last event, drain, then let the last scan settle
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("timestamp_kway_stream_merger: match");
    end else begin
      $display("timestamp_kway_stream_merger: mismatch");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timestamp_kway_stream_merger: mismatch");
    $finish;
  end

endmodule
